[rtl/tgarle_pkg.sv]
// Shared types and constants for the TGA run-length pixel decoder.
// Used by the parser, queue, expander and top modules; depends on nothing else.
package tgarle_pkg;

  // Default width of the pixel and row counters.
  localparam int DIM_BITS_DEFAULT = 16;

  // Depth of the job queue between the byte parser and the pixel expander.
  localparam int QUEUE_DEPTH = 2;

  // Packet header fields.
  localparam int        HDR_RUN_BIT = 7;
  localparam logic [6:0] COUNT_MASK = 7'h7f;

  // Alpha byte forced into every output pixel.
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Configuration register indexes.
  localparam int          CFG_INDEX_BITS = 2;
  localparam logic [1:0]  REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0]  REG_IMAGE_HEIGHT = 2'd1;

  // One decoded pixel and how many times it must be emitted.
  typedef struct packed {
    logic [23:0] colour;  // R in the high byte, then G, then B
    logic [7:0]  count;   // 1 to 128 copies
  } job_t;

  // One result as it leaves the expander.
  typedef struct packed {
    logic [31:0] first_pixel;
    logic [31:0] second_pixel;
    logic [1:0]  pair_count;
    logic        run_last;
    logic        image_done;
  } result_t;

endpackage

[rtl/tgarle_front.sv]
// Byte parser: reads packet headers and assembles BGRA pixels into jobs.
// Depends on tgarle_pkg for the job type and header constants.
module tgarle_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  output logic              byte_ready,
  input  logic              queue_full,
  output logic              push,
  output tgarle_pkg::job_t  push_job
);

  typedef enum logic [1:0] {
    ST_HEADER = 2'b01,
    ST_PIXEL  = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic        is_run_r, is_run_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [23:0] colour_r, colour_nxt;
  logic        accept;

  // A byte is taken only while the queue can hold a job it might complete.
  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  // Header decode and pixel assembly.
  always_comb begin
    state_nxt   = state_r;
    is_run_nxt  = is_run_r;
    left_nxt    = left_r;
    idx_nxt     = idx_r;
    colour_nxt  = colour_r;
    push        = 1'b0;
    push_job.colour = colour_r;
    push_job.count  = is_run_r ? left_r : 8'd1;
    if (accept) begin
      case (state_r)
        ST_HEADER: begin
          is_run_nxt = byte_data[tgarle_pkg::HDR_RUN_BIT];
          left_nxt   = {1'b0, byte_data[6:0] & tgarle_pkg::COUNT_MASK} + 8'd1;
          idx_nxt    = 2'd0;
          state_nxt  = ST_PIXEL;
        end
        ST_PIXEL: begin
          case (idx_r)
            2'd0: colour_nxt[7:0]   = byte_data;
            2'd1: colour_nxt[15:8]  = byte_data;
            2'd2: colour_nxt[23:16] = byte_data;
            default: begin
              // Alpha byte: the pixel is complete, the byte itself is dropped.
              push = 1'b1;
              left_nxt = is_run_r ? 8'd0 : left_r - 8'd1;
              if (left_nxt == 8'd0) begin
                state_nxt = ST_HEADER;
              end
            end
          endcase
          idx_nxt = idx_r + 2'd1;
        end
        default: state_nxt = ST_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r  <= ST_HEADER;
      is_run_r <= 1'b0;
      left_r   <= 8'd0;
      idx_r    <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      is_run_r <= is_run_nxt;
      left_r   <= left_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Colour bytes are payload and need no reset.
  always_ff @(posedge clk) begin
    colour_r <= colour_nxt;
  end

endmodule

[rtl/tgarle_fifo.sv]
// Short job queue that decouples the byte parser from the pixel expander.
// Depends on tgarle_pkg for the job type and queue depth.
module tgarle_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic              push,
  input  tgarle_pkg::job_t  push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output tgarle_pkg::job_t  head_job
);

  localparam int DEPTH    = tgarle_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  tgarle_pkg::job_t    slots_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full      = (count_r == CNT_BITS'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_job  = slots_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/tgarle_back.sv]
// Pixel expander: turns queued jobs into one- or two-pixel results and
// counts columns and rows to find the end of the image. Uses tgarle_pkg.
module tgarle_back #(
  parameter int DIM_BITS = tgarle_pkg::DIM_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  restart,
  input  logic [15:0]           image_width,
  input  logic [15:0]           image_height,
  input  logic                  job_valid,
  input  tgarle_pkg::job_t      job,
  output logic                  job_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output tgarle_pkg::result_t   res
);

  logic                busy_r;
  logic [23:0]         colour_r;
  logic [7:0]          left_r, left_nxt;
  logic [DIM_BITS-1:0] col_r, row_r;
  logic                fin_r;
  logic                out_valid_r;
  tgarle_pkg::result_t out_r;

  logic [DIM_BITS-1:0] w, h;
  logic [DIM_BITS-1:0] col_a, row_a, col1, row1, col_b, row_b, col2, row2;
  logic                wrap_a, wrap_b, done1, done2, two, done, job_end;
  logic                step;
  logic [31:0]         pix;

  assign w = image_width[DIM_BITS-1:0];
  assign h = image_height[DIM_BITS-1:0];

  // Jobs that arrive after the image has ended are popped and dropped.
  assign job_pop = !busy_r && job_valid;
  assign step    = busy_r && (!out_valid_r || res_ready);
  assign pix     = {colour_r, tgarle_pkg::ALPHA_OPAQUE};

  // First pixel of this result.
  always_comb begin
    col_a  = col_r + {{(DIM_BITS-1){1'b0}}, 1'b1};
    row_a  = row_r + {{(DIM_BITS-1){1'b0}}, 1'b1};
    wrap_a = (col_a == w);
    col1   = wrap_a ? '0 : col_a;
    row1   = wrap_a ? row_a : row_r;
    done1  = wrap_a && (row_a == h);
  end

  // Second pixel, taken only if copies remain and the image goes on.
  always_comb begin
    two    = (left_r > 8'd1) && !done1;
    col_b  = col1 + {{(DIM_BITS-1){1'b0}}, 1'b1};
    row_b  = row1 + {{(DIM_BITS-1){1'b0}}, 1'b1};
    wrap_b = (col_b == w);
    col2   = wrap_b ? '0 : col_b;
    row2   = wrap_b ? row_b : row1;
    done2  = wrap_b && (row_b == h);
    done   = two ? done2 : done1;
    left_nxt = left_r - (two ? 8'd2 : 8'd1);
    job_end  = (left_nxt == 8'd0) || done;
  end

  // Control state: job in progress, counters and end-of-image flag.
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      busy_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= 8'd0;
    end else begin
      if (job_pop) begin
        busy_r <= !fin_r;
        left_r <= job.count;
      end else if (step) begin
        busy_r <= !job_end;
        left_r <= left_nxt;
        col_r  <= two ? col2 : col1;
        row_r  <= two ? row2 : row1;
        fin_r  <= done;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (job_pop) begin
      colour_r <= job.colour;
    end
    if (step) begin
      out_r.first_pixel  <= pix;
      out_r.second_pixel <= two ? pix : 32'd0;
      out_r.pair_count   <= two ? 2'd2 : 2'd1;
      out_r.run_last     <= job_end;
      out_r.image_done   <= done;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

[rtl/tga_rle_pixel_decoder.sv]
// A pixel's job passes the job queue, the expander's job registers and its
// output register before its first result is valid. Throughput: one byte per
// cycle while the job queue has room; a run packet of N copies yields ceil(N/2)
// results, one per cycle unless stalled, once the expander has loaded the job from the queue.
// Reset (rst_n low, synchronous) and any size-register write restart decoding;
// reset also sets both size registers to 1.
module tga_rle_pixel_decoder #(
  parameter int DIM_BITS = tgarle_pkg::DIM_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // [31:0] first_pixel, [63:32] second_pixel,
                                   // [65:64] pair_count, [71:66] zero
  output logic        out_tlast,   // run_last
  output logic        out_tuser,   // [0] image_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [tgarle_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]         width_r, height_r;
  logic                cfg_write, restart;
  logic                queue_full, queue_not_empty, push, pop;
  tgarle_pkg::job_t    push_job, head_job;
  tgarle_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write && ((cfg_index == tgarle_pkg::REG_IMAGE_WIDTH) ||
                                   (cfg_index == tgarle_pkg::REG_IMAGE_HEIGHT));

  // Size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 16'd1;
      height_r <= 16'd1;
    end else if (cfg_write) begin
      if (cfg_index == tgarle_pkg::REG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == tgarle_pkg::REG_IMAGE_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  tgarle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .byte_valid (in_tvalid),
    .byte_data  (in_tdata),
    .byte_ready (in_tready),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  tgarle_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_job  (head_job)
  );

  tgarle_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .image_width  (width_r),
    .image_height (height_r),
    .job_valid    (queue_not_empty),
    .job          (head_job),
    .job_pop      (pop),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res          (res)
  );

  // Pack the result onto the stream.
  assign out_tdata = {6'd0, res.pair_count, res.second_pixel, res.first_pixel};
  assign out_tlast = res.run_last;
  assign out_tuser = res.image_done;

endmodule

[rtl/tgarle_checker.sv]
// Port-level checks for the TGA run-length pixel decoder, bound to the top.
// Depends on tga_rle_pixel_decoder's port list only.
module tgarle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Every result carries one or two pixels, and a single pixel leaves the
  // second slot at zero.
  a_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:64] == 2'd2) ||
                   (out_tdata[65:64] == 2'd1 && out_tdata[63:32] == 32'd0))
    else $error("bad pair count or second pixel");

  // Alpha is forced opaque.
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] == 8'hff)
    else $error("alpha byte not opaque");

  // The image's final pixel always closes the results of its job.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("image end without last flag");

  // Nothing follows the final pixel straight away.
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser |=> !out_tvalid)
    else $error("result after image end");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
